[rtl/scf_pkg.sv]
// Shared types, constants and helpers for the clipped shape fill canvas.
package scf_pkg;

	localparam int DEF_MAX_COLS = 256;
	localparam int DEF_MAX_ROWS = 256;

	localparam int IN_DATA_W   = 64;
	localparam int IN_USER_W   = 3;
	localparam int OUT_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;

	localparam int COORD_W = 14;
	localparam int ROWS_W  = 11;
	localparam int CNT_W   = 17;

	localparam int OUT_INB_BIT = 8;
	localparam int OUT_CNT_LSB = 9;

	localparam int Q_DEPTH = 2;
	localparam int QAW     = $clog2(Q_DEPTH);

	localparam logic [7:0] BLANK_CELL = 8'd46;

	localparam logic [CFG_INDEX_W-1:0] REG_COLS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 2'd1;

	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_RECT    = 3'd1;
	localparam logic [2:0] CMD_UP      = 3'd2;
	localparam logic [2:0] CMD_DOWN    = 3'd3;
	localparam logic [2:0] CMD_DIAMOND = 3'd4;
	localparam logic [2:0] CMD_READ    = 3'd5;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_CLEAR,
		OP_FILL,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		MODE_RECT,
		MODE_UP,
		MODE_DOWN,
		MODE_DIAMOND
	} mode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ROW,
		ST_SPAN,
		ST_WIPE,
		ST_READ,
		ST_DONE
	} st_t;

	typedef struct packed {
		op_t                        op;
		mode_t                      mode;
		logic signed [11:0]         x;
		logic signed [11:0]         y;
		logic signed [COORD_W-1:0]  hi0;
		logic [ROWS_W-1:0]          rows;
		logic [9:0]                 ext;
		logic [7:0]                 brush;
	} job_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] cols;
		logic [CFG_DATA_W-1:0] rows;
	} dims_t;

	typedef struct packed {
		logic init_busy;
	} status_t;

	function automatic logic signed [COORD_W-1:0] sext_coord(logic signed [11:0] v);
		return {{(COORD_W-12){v[11]}}, v};
	endfunction

endpackage

[rtl/scf_front.sv]
// Command intake, configuration registers and command classification.
module scf_front #(
	parameter int MAX_COLS = scf_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = scf_pkg::DEF_MAX_ROWS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [scf_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [scf_pkg::IN_USER_W-1:0]       s_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [scf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [scf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  scf_pkg::status_t                    status,
	output logic                                q_valid,
	input  logic                                q_ready,
	output scf_pkg::job_t                       q_job,
	output scf_pkg::dims_t                      dims
);
	import scf_pkg::*;

	logic [CFG_DATA_W-1:0] cols_q;
	logic [CFG_DATA_W-1:0] rows_q;
	logic [2:0]            cmd;
	logic signed [11:0]    x;
	logic signed [11:0]    y;
	logic [9:0]            w;
	logic [9:0]            h;
	logic [9:0]            e;
	logic [7:0]            brush;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 9'd256;
			rows_q <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLS: cols_q <= cfg_data;
				REG_ROWS: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dims.cols = (int'(cols_q) > MAX_COLS) ? CFG_DATA_W'(MAX_COLS) : cols_q;
	assign dims.rows = (int'(rows_q) > MAX_ROWS) ? CFG_DATA_W'(MAX_ROWS) : rows_q;

	assign cmd   = s_tuser[2:0];
	assign x     = s_tdata[11:0];
	assign y     = s_tdata[23:12];
	assign w     = s_tdata[33:24];
	assign h     = s_tdata[43:34];
	assign e     = s_tdata[53:44];
	assign brush = s_tdata[61:54];

	always_comb begin
		q_job       = '0;
		q_job.op    = OP_NOP;
		q_job.mode  = MODE_RECT;
		q_job.x     = x;
		q_job.y     = y;
		q_job.hi0   = sext_coord(x);
		q_job.ext   = e;
		q_job.brush = brush;
		case (cmd)
			CMD_CLEAR: begin
				q_job.op = OP_CLEAR;
			end
			CMD_RECT: begin
				q_job.op   = (w != 10'd0 && h != 10'd0) ? OP_FILL : OP_NOP;
				q_job.rows = {1'b0, h};
				q_job.hi0  = sext_coord(x) + $signed({4'b0, w}) - 14'sd1;
			end
			CMD_UP: begin
				q_job.op   = (e != 10'd0) ? OP_FILL : OP_NOP;
				q_job.mode = MODE_UP;
				q_job.rows = {1'b0, e};
			end
			CMD_DOWN: begin
				q_job.op   = (e != 10'd0) ? OP_FILL : OP_NOP;
				q_job.mode = MODE_DOWN;
				q_job.rows = {1'b0, e};
			end
			CMD_DIAMOND: begin
				q_job.op   = OP_FILL;
				q_job.mode = MODE_DIAMOND;
				q_job.rows = {e, 1'b1};
			end
			CMD_READ: begin
				q_job.op = OP_READ;
			end
			default: ;
		endcase
	end

	assign s_tready = q_ready && !status.init_busy;
	assign q_valid  = s_tvalid && !status.init_busy;

endmodule

[rtl/scf_queue.sv]
// Short job queue between the command front and the raster back.
module scf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  scf_pkg::job_t  push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output scf_pkg::job_t  pop_job
);
	import scf_pkg::*;

	job_t           slot_q [Q_DEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = cnt_q != (QAW+1)'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

[rtl/scf_back.sv]
// Raster engine: canvas memory, row and span walker, clear sweep and result register.
module scf_back #(
	parameter int MAX_COLS = scf_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = scf_pkg::DEF_MAX_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	output logic                            job_ready,
	input  scf_pkg::job_t                   job,
	input  scf_pkg::dims_t                  dims,
	output scf_pkg::status_t                status,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [scf_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import scf_pkg::*;

	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW    = CW + RW;
	localparam int DEPTH = 2 ** AW;

	st_t                        state_q;
	st_t                        state_d;
	job_t                       job_q;
	logic signed [COORD_W-1:0]  r_q;
	logic signed [COORD_W-1:0]  lo_q;
	logic signed [COORD_W-1:0]  hi_q;
	logic signed [COORD_W-1:0]  col_q;
	logic signed [COORD_W-1:0]  end_q;
	logic [ROWS_W-1:0]          k_q;
	logic [CNT_W-1:0]           count_q;
	logic [AW-1:0]              addr_q;
	logic [7:0]                 mem [DEPTH];
	logic [7:0]                 rd_data_q;
	logic                       m_valid_q;
	logic [OUT_DATA_W-1:0]      m_data_q;

	logic signed [COORD_W-1:0]  eff_cols_s;
	logic signed [COORD_W-1:0]  eff_rows_s;
	logic signed [COORD_W-1:0]  lo_c;
	logic signed [COORD_W-1:0]  hi_c;
	logic signed [COORD_W-1:0]  x_s;
	logic signed [COORD_W-1:0]  y_s;
	logic                       row_hit;
	logic                       span_last;
	logic                       row_end;
	logic                       last_row;
	logic                       sweep_last;
	logic                       out_free;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [7:0]                 mem_wdata;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic                       result_load;
	logic [2*CFG_DATA_W-1:0]    area;
	logic                       rd_hit;
	logic [7:0]                 res_value;
	logic                       res_inb;
	logic [CNT_W-1:0]           res_cnt;

	assign eff_cols_s = $signed({{(COORD_W-CFG_DATA_W){1'b0}}, dims.cols});
	assign eff_rows_s = $signed({{(COORD_W-CFG_DATA_W){1'b0}}, dims.rows});

	assign lo_c       = lo_q[COORD_W-1] ? '0 : lo_q;
	assign hi_c       = (hi_q >= eff_cols_s) ? eff_cols_s - 14'sd1 : hi_q;
	assign row_hit    = !r_q[COORD_W-1] && (r_q < eff_rows_s) && (lo_c <= hi_c);
	assign span_last  = col_q == end_q;
	assign row_end    = (state_q == ST_ROW && !row_hit) || (state_q == ST_SPAN && span_last);
	assign last_row   = ROWS_W'(k_q + 1'b1) == job_q.rows;
	assign sweep_last = &addr_q;
	assign out_free   = !m_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (job_valid) begin
					case (job.op)
						OP_CLEAR: state_d = ST_WIPE;
						OP_FILL:  state_d = ST_ROW;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_ROW: begin
				if (row_hit) state_d = ST_SPAN;
				else if (last_row) state_d = ST_DONE;
			end
			ST_SPAN: begin
				if (span_last) state_d = last_row ? ST_DONE : ST_ROW;
			end
			ST_WIPE: begin
				if (sweep_last) state_d = ST_DONE;
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready        = state_q == ST_IDLE;
		status.init_busy = state_q == ST_INIT;
		mem_we           = 1'b0;
		mem_waddr        = addr_q;
		mem_wdata        = BLANK_CELL;
		rd_en            = 1'b0;
		result_load      = 1'b0;
		case (state_q)
			ST_INIT, ST_WIPE: begin
				mem_we = 1'b1;
			end
			ST_SPAN: begin
				mem_we    = 1'b1;
				mem_waddr = {r_q[RW-1:0], col_q[CW-1:0]};
				mem_wdata = job_q.brush;
			end
			ST_READ: begin
				rd_en = 1'b1;
			end
			ST_DONE: begin
				result_load = out_free;
			end
			default: ;
		endcase
	end

	assign rd_addr = {job_q.y[RW-1:0], job_q.x[CW-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign area   = dims.cols * dims.rows;
	assign x_s    = sext_coord(job_q.x);
	assign y_s    = sext_coord(job_q.y);
	assign rd_hit = !x_s[COORD_W-1] && (x_s < eff_cols_s) &&
	                !y_s[COORD_W-1] && (y_s < eff_rows_s);

	always_comb begin
		res_value = '0;
		res_inb   = 1'b0;
		res_cnt   = '0;
		case (job_q.op)
			OP_CLEAR: res_cnt = area[CNT_W-1:0];
			OP_FILL:  res_cnt = count_q;
			OP_READ: begin
				res_inb   = rd_hit;
				res_value = rd_hit ? rd_data_q : 8'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			addr_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_WIPE) begin
				addr_q <= addr_q + 1'b1;
			end else if (state_q == ST_IDLE) begin
				addr_q <= '0;
			end
			if (result_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			job_q   <= job;
			r_q     <= sext_coord(job.y);
			lo_q    <= sext_coord(job.x);
			hi_q    <= job.hi0;
			k_q     <= '0;
			count_q <= '0;
		end
		if (state_q == ST_ROW && row_hit) begin
			col_q <= lo_c;
			end_q <= hi_c;
		end
		if (state_q == ST_SPAN) begin
			count_q <= count_q + 1'b1;
			col_q   <= col_q + 14'sd1;
		end
		if (row_end) begin
			k_q <= k_q + 1'b1;
			r_q <= (job_q.mode == MODE_DOWN) ? r_q - 14'sd1 : r_q + 14'sd1;
			case (job_q.mode)
				MODE_UP, MODE_DOWN: begin
					lo_q <= lo_q - 14'sd1;
					hi_q <= hi_q + 14'sd1;
				end
				MODE_DIAMOND: begin
					if (k_q < {1'b0, job_q.ext}) begin
						lo_q <= lo_q - 14'sd1;
						hi_q <= hi_q + 14'sd1;
					end else begin
						lo_q <= lo_q + 14'sd1;
						hi_q <= hi_q - 14'sd1;
					end
				end
				default: ;
			endcase
		end
		if (result_load) begin
			m_data_q <= OUT_DATA_W'({res_cnt, res_inb, res_value});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

[rtl/clipped_shape_fill_canvas.sv]
// Top level of the clipped shape fill canvas: front, job queue and raster back.
//
// Each command yields one result. The back writes one canvas cell per clock through a
// single-port byte memory of 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells; a fill visits
// each of its rows in turn and paints the clipped span of each, and a clear sweeps the
// whole memory. After reset the same sweep runs once to blank the canvas and s_tready
// stays low until it is done; configuration writes are taken throughout. The two-entry
// queue lets up to two further commands be accepted while the back is busy and a result
// waits on m_tready.
module clipped_shape_fill_canvas #(
	parameter int MAX_COLS = scf_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = scf_pkg::DEF_MAX_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// x_pos[11:0], y_pos[23:12], rect_width[33:24], rect_height[43:34],
	// extent[53:44], brush[61:54], zero[63:62]
	input  logic [scf_pkg::IN_DATA_W-1:0]    s_tdata,
	// command[2:0]
	input  logic [scf_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_value[7:0], in_bounds[8], pixels_written[25:9], zero[31:26]
	output logic [scf_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [scf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [scf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import scf_pkg::*;

	status_t status;
	dims_t   dims;
	logic    fq_valid;
	logic    fq_ready;
	job_t    fq_job;
	logic    qb_valid;
	logic    qb_ready;
	job_t    qb_job;

	scf_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_job     (fq_job),
		.dims      (dims)
	);

	scf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	scf_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.dims      (dims),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

[rtl/scf_checker.sv]
// Port-level checks for the clipped shape fill canvas, bound to the top level.
module scf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [scf_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import scf_pkg::*;

	a_init_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !s_tready)
		else $error("Input accepted while the canvas is still being blanked.");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result changed or vanished before its transaction.");

	a_read_writes_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_INB_BIT] |-> m_tdata[OUT_CNT_LSB +: CNT_W] == '0)
		else $error("A read result reports painted cells.");

	a_outside_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[OUT_INB_BIT] |-> m_tdata[7:0] == 8'd0)
		else $error("Nonzero cell value outside the active canvas.");

endmodule

bind clipped_shape_fill_canvas scf_checker u_scf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
